// ----- hdl/cfls_pkg.sv -----
`timescale 1ns / 1ps

package cfls_pkg;

  // point counter width and the number of points a fit can cover
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MAX_POINTS = 7'd64;
  localparam logic [CNT_W-1:0] MIN_POINTS_RST = 7'd30;

  // job queue depth between front and back
  localparam int QDEPTH = 2;

  // datapath widths of the solver
  localparam int OP_W = 64;
  localparam int WIDE_W = 128;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  typedef struct packed {
    logic [13:0] x_coord;
    logic [12:0] y_coord;
    logic        last_point;
  } pt_in_t;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        radius;
    logic [1:0]         status;
  } fit_out_t;

  // snapshot of the sums of one point set
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [19:0]      sx;
    logic [19:0]      sy;
    logic [32:0]      sxx;
    logic [32:0]      syy;
    logic [32:0]      sxy;
    logic [46:0]      sxxx;
    logic [46:0]      syyy;
    logic [46:0]      sxyy;
    logic [46:0]      sxxy;
    logic             ovf;
  } job_t;

endpackage

// ----- hdl/circle_fit_least_squares_top.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    pt_in_t: x_coord, y_coord, last_point
// out_     output     out_valid/out_ready  fit_out_t: center_x, center_y, radius, status
// cfg_     input      cfg_wr_en            cfg_wr_data: min_points
//
// A point passes through the accumulator steps in order: capture, squares, cubes, sum;
// the last point of a set adds a push step that hands the set to the job queue.
// The solver works each set with 22 products on the shared
// 64x16-per-cycle multiplier, three 128-step divides and a 32-step square root.
// Reset is synchronous, active low; it clears sums, queue and min_points to 30.
// A full queue stalls the accumulator on a last point; a stalled output holds
// the solver in its output step while the queue keeps taking sets until full.
module circle_fit_least_squares_top import cfls_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pt_in_t           in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fit_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  logic [CNT_W-1:0] min_points_r;
  logic             push_valid, push_ready;
  job_t             push_job;
  logic             pop_valid, pop_ready;
  job_t             pop_job;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) min_points_r <= MIN_POINTS_RST;
    else if (cfg_wr_en) min_points_r <= cfg_wr_data;
  end

  cfls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  cfls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  cfls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_points (min_points_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- hdl/cfls_front.sv -----
`timescale 1ns / 1ps

module cfls_front import cfls_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pt_in_t in_data,
  output logic   push_valid,
  input  logic   push_ready,
  output job_t   push_job
);

  typedef enum logic [2:0] {F_IDLE, F_SQ, F_CUBE, F_ACC, F_PUSH} fstate_t;

  fstate_t     state_r, state_nxt;
  logic [13:0] x_r;
  logic [12:0] y_r;
  logic        last_r;
  logic [27:0] xx_r;
  logic [25:0] yy_r;
  logic [26:0] xy_r;
  logic [41:0] xxx_r;
  logic [38:0] yyy_r;
  logic [39:0] xyy_r;
  logic [40:0] xxy_r;
  job_t        acc_r;

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_job   = acc_r;

  // sequence: take point, squares, cubes, accumulate, hand off set
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_SQ;
      F_SQ:   state_nxt = F_CUBE;
      F_CUBE: state_nxt = F_ACC;
      F_ACC:  state_nxt = last_r ? F_PUSH : F_IDLE;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        F_IDLE: if (in_valid) begin
          x_r    <= in_data.x_coord;
          y_r    <= in_data.y_coord;
          last_r <= in_data.last_point;
        end
        F_SQ: begin
          xx_r <= 28'(x_r) * 28'(x_r);
          yy_r <= 26'(y_r) * 26'(y_r);
          xy_r <= 27'(x_r) * 27'(y_r);
        end
        F_CUBE: begin
          xxx_r <= 42'(xx_r) * 42'(x_r);
          yyy_r <= 39'(yy_r) * 39'(y_r);
          xyy_r <= 40'(yy_r) * 40'(x_r);
          xxy_r <= 41'(xx_r) * 41'(y_r);
        end
        F_ACC: begin
          // points past the limit are dropped and flagged
          if (acc_r.count < MAX_POINTS) begin
            acc_r.count <= acc_r.count + 7'd1;
            acc_r.sx    <= acc_r.sx + 20'(x_r);
            acc_r.sy    <= acc_r.sy + 20'(y_r);
            acc_r.sxx   <= acc_r.sxx + 33'(xx_r);
            acc_r.syy   <= acc_r.syy + 33'(yy_r);
            acc_r.sxy   <= acc_r.sxy + 33'(xy_r);
            acc_r.sxxx  <= acc_r.sxxx + 47'(xxx_r);
            acc_r.syyy  <= acc_r.syyy + 47'(yyy_r);
            acc_r.sxyy  <= acc_r.sxyy + 47'(xyy_r);
            acc_r.sxxy  <= acc_r.sxxy + 47'(xxy_r);
          end else begin
            acc_r.ovf <= 1'b1;
          end
        end
        F_PUSH: if (push_ready) acc_r <= '0;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/cfls_queue.sv -----
`timescale 1ns / 1ps

module cfls_queue import cfls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  job_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- hdl/cfls_mul.sv -----
`timescale 1ns / 1ps

// signed 64x64 multiply, one 64x16 partial product per cycle
module cfls_mul import cfls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OP_W-1:0]   a,
  input  logic [OP_W-1:0]   b,
  output logic              done,
  output logic [WIDE_W-1:0] prod
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

  mstate_t           state_r;
  logic [OP_W-1:0]   ma_r, mb_r;
  logic              neg_r;
  logic [WIDE_W-1:0] acc_r, prod_r;
  logic [1:0]        k_r;
  logic              done_r;
  logic [15:0]       digit;
  logic [79:0]       pp;
  logic [WIDE_W-1:0] pp_sh;

  assign done  = done_r;
  assign prod  = prod_r;
  assign digit = mb_r[{k_r, 4'b0000} +: 16];
  assign pp    = 80'(ma_r) * 80'(digit);
  assign pp_sh = {48'd0, pp} << {k_r, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      // done pulses for one cycle after the sign fix
      done_r <= (state_r == M_FIX);
      unique case (state_r)
        M_IDLE: if (start) begin
          ma_r    <= a[OP_W-1] ? (OP_W'(0) - a) : a;
          mb_r    <= b[OP_W-1] ? (OP_W'(0) - b) : b;
          neg_r   <= a[OP_W-1] ^ b[OP_W-1];
          acc_r   <= '0;
          k_r     <= '0;
          state_r <= M_RUN;
        end
        M_RUN: begin
          acc_r <= acc_r + pp_sh;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd3) state_r <= M_FIX;
        end
        M_FIX: begin
          prod_r  <= neg_r ? (WIDE_W'(0) - acc_r) : acc_r;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/cfls_div.sv -----
`timescale 1ns / 1ps

// unsigned restoring divider, one quotient bit per cycle
module cfls_div import cfls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] dividend,
  input  logic [WIDE_W-1:0] divisor,
  output logic              done,
  output logic [WIDE_W-1:0] quo
);

  localparam int CW = $clog2(WIDE_W);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t           state_r;
  logic [WIDE_W:0]   rem_r;
  logic [WIDE_W-1:0] quo_r, den_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [WIDE_W:0]   rem_sh;
  logic [WIDE_W+1:0] diff;
  logic              fits;

  assign done   = done_r;
  assign quo    = quo_r;
  assign rem_sh = {rem_r[WIDE_W-1:0], quo_r[WIDE_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign fits   = !diff[WIDE_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      // done pulses once the last quotient bit is in
      done_r <= (state_r == D_RUN) && (cnt_r == CW'(WIDE_W-1));
      unique case (state_r)
        D_IDLE: if (start) begin
          rem_r   <= '0;
          quo_r   <= dividend;
          den_r   <= divisor;
          cnt_r   <= '0;
          state_r <= D_RUN;
        end
        D_RUN: begin
          rem_r <= fits ? diff[WIDE_W:0] : rem_sh;
          quo_r <= {quo_r[WIDE_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(WIDE_W-1)) state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/cfls_back.sv -----
`timescale 1ns / 1ps

module cfls_back import cfls_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] min_points,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  job_t             pop_job,
  output logic             out_valid,
  input  logic             out_ready,
  output fit_out_t         out_data
);

  typedef enum logic [3:0] {
    B_IDLE, B_MA, B_MAW, B_MB, B_MBW, B_CHK, B_DX, B_DXW, B_DY, B_DYW,
    B_QCHK, B_DQ, B_DQW, B_SQ, B_OUT
  } bstate_t;

  // product-pair steps: each forms first product minus second product
  localparam logic [3:0] PR_C   = 4'd0;
  localparam logic [3:0] PR_D   = 4'd1;
  localparam logic [3:0] PR_G   = 4'd2;
  localparam logic [3:0] PR_E   = 4'd3;
  localparam logic [3:0] PR_H   = 4'd4;
  localparam logic [3:0] PR_DET = 4'd5;
  localparam logic [3:0] PR_NX  = 4'd6;
  localparam logic [3:0] PR_NY  = 4'd7;
  localparam logic [3:0] PR_M   = 4'd8;
  localparam logic [3:0] PR_R2  = 4'd9;
  localparam logic [3:0] PR_T   = 4'd10;

  bstate_t           state_r;
  logic [3:0]        pair_r;
  logic [CNT_W-1:0]  n_r;
  logic [19:0]       sx_r, sy_r;
  logic [32:0]       sxx_r, syy_r, sxy_r;
  logic [33:0]       s2_r;
  logic [47:0]       s3x_r, s3y_r;
  logic              ovf_r;
  logic [OP_W-1:0]   c_r, d_r, g_r, e_r, h_r, m_r, r2_r, t_r, q_r;
  logic [WIDE_W-1:0] det_r, numx_r, numy_r, p_r;
  logic [15:0]       cx_r, cy_r, radius_r;
  logic [1:0]        status_r;
  logic [OP_W-1:0]   v_r, rt_r, bit_r;
  logic [4:0]        sq_cnt_r;
  logic              out_valid_r;
  fit_out_t          out_data_r;

  logic [OP_W-1:0]   n64, sx64, sy64, cx64, cy64, op_a, op_b;
  logic              mul_start, mul_done;
  logic [WIDE_W-1:0] mul_prod, pair_diff;
  logic              div_start, div_done;
  logic [WIDE_W-1:0] div_a, div_b, div_quo, num_sel, mn, md;
  logic              div_neg;
  logic [OP_W-1:0]   q_sum;
  logic [OP_W-1:0]   sq_sum, rt_nxt, v_nxt, rnd;
  logic              sq_ge;

  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n64  = {57'd0, n_r};
  assign sx64 = {44'd0, sx_r};
  assign sy64 = {44'd0, sy_r};
  assign cx64 = {{48{cx_r[15]}}, cx_r};
  assign cy64 = {{48{cy_r[15]}}, cy_r};

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == B_MA) begin
      unique case (pair_r)
        PR_C:   begin op_a = n64;  op_b = {31'd0, sxx_r}; end
        PR_D:   begin op_a = n64;  op_b = {31'd0, sxy_r}; end
        PR_G:   begin op_a = n64;  op_b = {31'd0, syy_r}; end
        PR_E:   begin op_a = n64;  op_b = {16'd0, s3x_r}; end
        PR_H:   begin op_a = n64;  op_b = {16'd0, s3y_r}; end
        PR_DET: begin op_a = c_r;  op_b = g_r; end
        PR_NX:  begin op_a = e_r;  op_b = g_r; end
        PR_NY:  begin op_a = h_r;  op_b = c_r; end
        PR_M:   begin op_a = cx64; op_b = sx64; end
        PR_R2:  begin op_a = cx64; op_b = cx64; end
        PR_T:   begin op_a = n64;  op_b = r2_r; end
        default: ;
      endcase
    end else begin
      unique case (pair_r)
        PR_C:   begin op_a = sx64; op_b = sx64; end
        PR_D:   begin op_a = sx64; op_b = sy64; end
        PR_G:   begin op_a = sy64; op_b = sy64; end
        PR_E:   begin op_a = {30'd0, s2_r}; op_b = sx64; end
        PR_H:   begin op_a = {30'd0, s2_r}; op_b = sy64; end
        PR_DET: begin op_a = d_r;  op_b = d_r; end
        PR_NX:  begin op_a = h_r;  op_b = d_r; end
        PR_NY:  begin op_a = e_r;  op_b = d_r; end
        PR_M:   begin op_a = OP_W'(0) - cy64; op_b = sy64; end
        PR_R2:  begin op_a = OP_W'(0) - cy64; op_b = cy64; end
        PR_T:   begin op_a = {m_r[OP_W-2:0], 1'b0}; op_b = OP_W'(1); end
        default: ;
      endcase
    end
  end

  assign mul_start = (state_r == B_MA) || (state_r == B_MB);
  assign pair_diff = p_r - mul_prod;

  cfls_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // rounded quotient num / (2*det) runs as (|num| + |det|) / (2*|det|)
  assign num_sel = (state_r == B_DX || state_r == B_DXW) ? numx_r : numy_r;
  assign mn      = num_sel[WIDE_W-1] ? (WIDE_W'(0) - num_sel) : num_sel;
  assign md      = det_r[WIDE_W-1] ? (WIDE_W'(0) - det_r) : det_r;
  assign div_neg = num_sel[WIDE_W-1] ^ det_r[WIDE_W-1];

  always_comb begin
    if (state_r == B_DQ) begin
      div_a = {64'd0, q_r[OP_W-3:0], 2'b00};
      div_b = {121'd0, n_r};
    end else begin
      div_a = mn + md;
      div_b = {md[WIDE_W-2:0], 1'b0};
    end
  end

  assign div_start = (state_r == B_DX) || (state_r == B_DY) || (state_r == B_DQ);

  cfls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo)
  );

  function automatic logic [15:0] sat_q(input logic [WIDE_W-1:0] q, input logic neg);
    logic big;
    big = |q[WIDE_W-1:16];
    if (neg) begin
      if (big || q[15:0] > 16'd32768) sat_q = 16'h8000;
      else sat_q = 16'd0 - q[15:0];
    end else begin
      if (big || q[15]) sat_q = 16'h7fff;
      else sat_q = q[15:0];
    end
  endfunction

  // sum of squared distances to the emitted centre
  assign q_sum = {30'd0, s2_r} + t_r;

  // one step of the bitwise integer square root
  assign sq_sum = rt_r + bit_r;
  assign sq_ge  = (v_r >= sq_sum);
  assign rt_nxt = sq_ge ? ((rt_r >> 1) + bit_r) : (rt_r >> 1);
  assign v_nxt  = sq_ge ? (v_r - sq_sum) : v_r;
  assign rnd    = (rt_nxt + OP_W'(1)) >> 1;

  // solver sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      pair_r      <= PR_C;
    end else begin
      // the output step reloads valid itself
      if (out_valid_r && out_ready && state_r != B_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: if (pop_valid) begin
          n_r      <= pop_job.count;
          sx_r     <= pop_job.sx;
          sy_r     <= pop_job.sy;
          sxx_r    <= pop_job.sxx;
          syy_r    <= pop_job.syy;
          sxy_r    <= pop_job.sxy;
          s2_r     <= 34'(pop_job.sxx) + 34'(pop_job.syy);
          s3x_r    <= 48'(pop_job.sxxx) + 48'(pop_job.sxyy);
          s3y_r    <= 48'(pop_job.sxxy) + 48'(pop_job.syyy);
          ovf_r    <= pop_job.ovf;
          cx_r     <= '0;
          cy_r     <= '0;
          radius_r <= '0;
          pair_r   <= PR_C;
          state_r  <= B_MA;
        end
        B_MA: state_r <= B_MAW;
        B_MAW: if (mul_done) begin
          p_r     <= mul_prod;
          state_r <= B_MB;
        end
        B_MB: state_r <= B_MBW;
        B_MBW: if (mul_done) begin
          unique case (pair_r)
            PR_C:   c_r    <= pair_diff[OP_W-1:0];
            PR_D:   d_r    <= pair_diff[OP_W-1:0];
            PR_G:   g_r    <= pair_diff[OP_W-1:0];
            PR_E:   e_r    <= pair_diff[OP_W-1:0];
            PR_H:   h_r    <= pair_diff[OP_W-1:0];
            PR_DET: det_r  <= pair_diff;
            PR_NX:  numx_r <= pair_diff;
            PR_NY:  numy_r <= pair_diff;
            PR_M:   m_r    <= pair_diff[OP_W-1:0];
            PR_R2:  r2_r   <= pair_diff[OP_W-1:0];
            PR_T:   t_r    <= pair_diff[OP_W-1:0];
            default: ;
          endcase
          if (pair_r == PR_NY) begin
            state_r <= B_CHK;
          end else if (pair_r == PR_T) begin
            state_r <= B_QCHK;
          end else begin
            pair_r  <= pair_r + 4'd1;
            state_r <= B_MA;
          end
        end
        B_CHK: begin
          if (n_r < min_points) begin
            status_r <= ST_FEW;
            state_r  <= B_OUT;
          end else if (det_r == '0 || n_r == '0) begin
            status_r <= ST_DEGEN;
            state_r  <= B_OUT;
          end else begin
            state_r <= B_DX;
          end
        end
        B_DX: state_r <= B_DXW;
        B_DXW: if (div_done) begin
          cx_r    <= sat_q(div_quo, div_neg);
          state_r <= B_DY;
        end
        B_DY: state_r <= B_DYW;
        B_DYW: if (div_done) begin
          cy_r    <= sat_q(div_quo, div_neg);
          pair_r  <= PR_M;
          state_r <= B_MA;
        end
        B_QCHK: begin
          // a negative sum only comes from wrapped sums
          if (q_sum[OP_W-1]) begin
            status_r <= ST_DEGEN;
            cx_r     <= '0;
            cy_r     <= '0;
            state_r  <= B_OUT;
          end else begin
            q_r     <= q_sum;
            state_r <= B_DQ;
          end
        end
        B_DQ: state_r <= B_DQW;
        B_DQW: if (div_done) begin
          v_r      <= div_quo[OP_W-1:0];
          rt_r     <= '0;
          bit_r    <= OP_W'(1) << (OP_W - 2);
          sq_cnt_r <= '0;
          state_r  <= B_SQ;
        end
        B_SQ: begin
          v_r      <= v_nxt;
          rt_r     <= rt_nxt;
          bit_r    <= bit_r >> 2;
          sq_cnt_r <= sq_cnt_r + 5'd1;
          if (sq_cnt_r == 5'd31) begin
            radius_r <= (|rnd[OP_W-1:16]) ? 16'hffff : rnd[15:0];
            status_r <= ovf_r ? ST_OVF : ST_OK;
            state_r  <= B_OUT;
          end
        end
        B_OUT: if (!out_valid_r || out_ready) begin
          out_data_r.center_x <= cx_r;
          out_data_r.center_y <= cy_r;
          out_data_r.radius   <= radius_r;
          out_data_r.status   <= status_r;
          out_valid_r         <= 1'b1;
          state_r             <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == B_MAW || state_r == B_MBW))
    else $error("multiplier result arrived outside a wait step");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DXW || state_r == B_DYW || state_r == B_DQW))
    else $error("divider result arrived outside a wait step");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_FEW || out_data_r.status == ST_DEGEN))
    |-> (out_data_r.center_x == '0 && out_data_r.center_y == '0 &&
         out_data_r.radius == '0))
    else $error("failed fit carries nonzero fields");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == B_OUT))
    else $error("result loaded outside the output step");
`endif

endmodule

// ----- verif/fit_checker.sv -----
`timescale 1ns / 1ps

module fit_checker import cfls_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  pt_in_t           in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  fit_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               pending
);

  // predictor copy of the register and the sums
  logic [6:0]  min_pts;
  logic [6:0]  n_pts;
  logic [19:0] s_x, s_y;
  logic [32:0] s_xx, s_yy, s_xy;
  logic [46:0] s_xxx, s_yyy, s_xyy, s_xxy;
  logic        dropped;

  fit_out_t fits_due[$];

  function automatic void clear_sums();
    n_pts = '0;
    s_x = '0; s_y = '0;
    s_xx = '0; s_yy = '0; s_xy = '0;
    s_xxx = '0; s_yyy = '0; s_xyy = '0; s_xxy = '0;
    dropped = 1'b0;
  endfunction

  // round num / (2*den) half away from zero, saturate to 16 bit signed
  function automatic logic signed [15:0] round_center(logic signed [127:0] num,
                                                      logic signed [127:0] den);
    logic [127:0] mn, md, quo;
    logic         neg;
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    quo = (mn + md) / (md + md);
    if (neg) begin
      if (quo > 128'd32768) return 16'sh8000;
      return -quo[15:0];
    end
    if (quo > 128'd32767) return 16'sh7fff;
    return quo[15:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // solve the fit over the current sums
  function automatic fit_out_t solve_circle();
    fit_out_t            res;
    longint              n, sx, sy, sxx, syy, sxy, c, d, g, e, h, cx, cy, q;
    logic signed [127:0] wc, wd, wg, we, wh, det;
    logic [63:0]         rad, v;
    n = n_pts; sx = s_x; sy = s_y;
    sxx = s_xx; syy = s_yy; sxy = s_xy;
    c = n * sxx - sx * sx;
    d = n * sxy - sx * sy;
    g = n * syy - sy * sy;
    e = n * (longint'(s_xxx) + longint'(s_xyy)) - (sxx + syy) * sx;
    h = n * (longint'(s_xxy) + longint'(s_yyy)) - (sxx + syy) * sy;
    wc = c; wd = d; wg = g; we = e; wh = h;
    det = wc * wg - wd * wd;
    res = '0;
    if (n_pts < min_pts) begin
      res.status = ST_FEW;
    end else if (det == 0 || n == 0) begin
      res.status = ST_DEGEN;
    end else begin
      res.center_x = round_center(we * wg - wh * wd, det);
      res.center_y = round_center(wh * wc - we * wd, det);
      cx = longint'(res.center_x);
      cy = longint'(res.center_y);
      q = sxx + syy - 2 * cx * sx - 2 * cy * sy + n * (cx * cx + cy * cy);
      if (q < 0) begin
        res.status = ST_DEGEN;
        res.center_x = '0;
        res.center_y = '0;
      end else begin
        v = (64'(q) * 64'd4) / 64'(n);
        rad = (int_sqrt(v) + 64'd1) >> 1;
        res.radius = (rad > 64'd65535) ? 16'hffff : rad[15:0];
        res.status = dropped ? ST_OVF : ST_OK;
      end
    end
    return res;
  endfunction

  function automatic void add_point(pt_in_t p);
    logic [63:0] x, y;
    fit_out_t    fit;
    x = p.x_coord;
    y = p.y_coord;
    if (n_pts < MAX_POINTS) begin
      n_pts = n_pts + 7'd1;
      s_x   = s_x + x[19:0];
      s_y   = s_y + y[19:0];
      s_xx  = s_xx + 33'(x * x);
      s_yy  = s_yy + 33'(y * y);
      s_xy  = s_xy + 33'(x * y);
      s_xxx = s_xxx + 47'(x * x * x);
      s_yyy = s_yyy + 47'(y * y * y);
      s_xyy = s_xyy + 47'(x * y * y);
      s_xxy = s_xxy + 47'(x * x * y);
    end else begin
      dropped = 1'b1;
    end
    if (p.last_point) begin
      fit = solve_circle();
      fits_due.insert(fits_due.size(), fit);
      clear_sums();
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = fits_due.size();

  always @(posedge clk) begin
    fit_out_t want;
    if (!rst_n) begin
      min_pts = MIN_POINTS_RST;
      clear_sums();
    end else begin
      if (cfg_wr_en) min_pts = cfg_wr_data;
      // result transfer
      if (out_valid && out_ready) begin
        if (fits_due.size() == 0) begin
          $display("[%0t] result transfer with no fit pending", $realtime);
          fail_count++;
        end else begin
          want = fits_due.pop_front();
          if (out_data.center_x !== want.center_x)
            report("center_x", out_data.center_x, want.center_x);
          if (out_data.center_y !== want.center_y)
            report("center_y", out_data.center_y, want.center_y);
          if (out_data.radius !== want.radius)
            report("radius", out_data.radius, want.radius);
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
        end
      end
      // point transfer
      if (in_valid && in_ready) add_point(in_data);
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb import cfls_pkg::*;;

  localparam int CYCLE_LIMIT = 500000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  pt_in_t           in_data;
  logic             out_valid;
  logic             out_ready;
  fit_out_t         out_data;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  int               fail_count;
  int               pending;
  int               cycles;
  int               points_sent;
  int               sets_sent;
  logic             no_gaps;

  circle_fit_least_squares_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall before each transfer, none while no_gaps is set
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one point transfer; valid stays up between back-to-back points
  task automatic send_point(int x, int y, bit last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data.x_coord    <= 14'(x);
    in_data.y_coord    <= 13'(y);
    in_data.last_point <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  // hold off until every fit is out, then let the solver settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_min_points(int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // shapes: 0 circle, 1 noise, 2 line, 3 one spot, 4 full-width noise
  task automatic send_set(int count, int shape);
    int  cx, cy, r, px, py, dx, dy;
    real ang;
    cx = $urandom_range(0, 10239);
    cy = $urandom_range(0, 7679);
    r  = $urandom_range(16, 4000);
    dx = $urandom_range(0, 200);
    dy = $urandom_range(0, 200);
    for (int i = 0; i < count; i++) begin
      case (shape)
        0: begin
          ang = $urandom_range(0, 6283) / 1000.0;
          px = cx + $rtoi(r * $cos(ang)) + $urandom_range(0, 2);
          py = cy + $rtoi(r * $sin(ang)) + $urandom_range(0, 2);
        end
        2: begin
          px = (i * dx) % 10240;
          py = (i * dy) % 7680;
        end
        3: begin
          px = cx;
          py = cy;
        end
        4: begin
          px = $urandom_range(0, 16383);
          py = $urandom_range(0, 8191);
        end
        default: begin
          px = $urandom_range(0, 10239);
          py = $urandom_range(0, 7679);
        end
      endcase
      if (px < 0) px = 0;
      if (px > 10239 && shape != 4) px = 10239;
      if (py < 0) py = 0;
      if (py > 7679 && shape != 4) py = 7679;
      send_point(px, py, i == count - 1);
    end
    sets_sent++;
  endtask

  initial begin
    int min_list[8];
    int phase, sel, count;
    min_list = '{3, 64, 127, 100, 0, 1, 12, 30};
    cycles      = 0;
    points_sent = 0;
    sets_sent   = 0;
    no_gaps     = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset threshold, lone points at the corners and full-width codes
    send_point(10239, 7679, 1'b1);
    send_point(16383, 8191, 1'b1);
    send_point(0, 0, 1'b1);
    write_min_points(3);
    // corners of the frame give a valid circle
    send_point(0, 0, 1'b0);
    send_point(10239, 0, 1'b0);
    send_point(0, 7679, 1'b1);
    send_point(10239, 7679, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(10239, 0, 1'b0);
    send_point(0, 7679, 1'b1);
    // collinear and coincident points are degenerate
    send_set(4, 2);
    send_set(3, 3);
    send_set(2, 1);
    // more points than the fit holds
    send_set(70, 0);

    // random phases across thresholds
    phase = 0;
    while (points_sent < 650 || sets_sent < 40) begin
      write_min_points(min_list[phase % 8]);
      no_gaps = (phase % 3 == 2);
      for (int s = 0; s < 4; s++) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) count = $urandom_range(65, 72);
        else if (sel < 3) count = $urandom_range(40, 64);
        else count = $urandom_range(1, 16);
        sel = $urandom_range(0, 9);
        send_set(count, sel < 6 ? 0 : sel < 8 ? 1 : sel == 8 ? 2 + (count % 2) : 4);
      end
      phase++;
    end
    no_gaps = 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cfls_pkg.sv
hdl/cfls_front.sv
hdl/cfls_queue.sv
hdl/cfls_mul.sv
hdl/cfls_div.sv
hdl/cfls_back.sv
hdl/circle_fit_least_squares_top.sv
verif/fit_checker.sv
verif/tb.sv
